[rtl/cobs_crc_frame_decoder_assert.svh]
// assertion macros shared by the decoder modules
`ifndef COBS_CRC_FRAME_DECODER_ASSERT_SVH
`define COBS_CRC_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CCFD_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("ccfd assertion failed");

// next-cycle implication, checked out of reset
`define CCFD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("ccfd assertion failed");

`endif

[rtl/ccfd_pkg.sv]
package ccfd_pkg;

    localparam int unsigned HDR_BYTES    = 6;
    localparam int unsigned RAW_OVERHEAD = 8;

    localparam int unsigned POS_VERSION  = 0;
    localparam int unsigned POS_TYPE     = 1;
    localparam int unsigned POS_SEQ_LO   = 2;
    localparam int unsigned POS_SEQ_HI   = 3;
    localparam int unsigned POS_LEN_LO   = 4;
    localparam int unsigned POS_LEN_HI   = 5;
    localparam int unsigned POS_CRC_FEED = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  CODE_FULL = 8'hFF;
    localparam logic [7:0]  CODE_EMPTY = 8'h01;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_COBS   = 3'd1,
        ST_SHORT  = 3'd2,
        ST_LENGTH = 3'd3,
        ST_CRC    = 3'd4
    } t_status;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        t_status     status;
        logic [7:0]  frame_version;
        logic [7:0]  frame_type;
        logic [15:0] frame_sequence;
        logic [15:0] frame_length;
    } t_result;

endpackage

[rtl/ccfd_dec.sv]
`include "cobs_crc_frame_decoder_assert.svh"

module ccfd_dec #(
    parameter int unsigned MAX_PAYLOAD = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output ccfd_pkg::t_result o_res
);

    localparam int unsigned RAW_CAP = MAX_PAYLOAD + ccfd_pkg::RAW_OVERHEAD;
    localparam int unsigned CW      = $clog2(RAW_CAP + 2);

    logic [7:0]        r_group_left, n_group_left;
    logic              r_group_full, n_group_full;
    logic              r_zero_owed, n_zero_owed;
    logic [CW-1:0]     r_raw_count, n_raw_count;
    logic [15:0]       r_crc_acc, n_crc_acc;
    logic [15:0]       r_crc_tail, n_crc_tail;
    logic [7:0]        r_version, n_version;
    logic [7:0]        r_type, n_type;
    logic [15:0]       r_sequence, n_sequence;
    logic [15:0]       r_length, n_length;
    ccfd_pkg::t_status r_first_error, n_first_error;

    logic              raw_en;
    logic [7:0]        raw_b;
    logic [31:0]       raw_pos;
    logic [31:0]       pay_pos;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ ccfd_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign raw_pos = 32'(r_raw_count);
    assign pay_pos = raw_pos - 32'(ccfd_pkg::HDR_BYTES);

    always_comb begin
        n_group_left  = r_group_left;
        n_group_full  = r_group_full;
        n_zero_owed   = r_zero_owed;
        n_raw_count   = r_raw_count;
        n_crc_acc     = r_crc_acc;
        n_crc_tail    = r_crc_tail;
        n_version     = r_version;
        n_type        = r_type;
        n_sequence    = r_sequence;
        n_length      = r_length;
        n_first_error = r_first_error;
        raw_en        = 1'b0;
        raw_b         = 8'h00;
        o_res_valid   = 1'b0;
        o_res         = '0;

        if (i_accept && i_byte != 8'h00) begin
            if (r_group_left == 8'h00) begin
                raw_en       = r_zero_owed;
                raw_b        = 8'h00;
                n_group_left = i_byte - 8'd1;
                n_group_full = (i_byte == ccfd_pkg::CODE_FULL);
                n_zero_owed  = (i_byte == ccfd_pkg::CODE_EMPTY);
            end else begin
                n_group_left = r_group_left - 8'd1;
                if (r_group_left == 8'd1) begin
                    n_zero_owed = !r_group_full;
                end
                raw_en = 1'b1;
                raw_b  = i_byte;
            end
        end

        if (raw_en) begin
            if (raw_pos >= RAW_CAP) begin
                n_first_error = ccfd_pkg::ST_LENGTH;
                n_raw_count   = CW'(RAW_CAP + 1);
            end else begin
                n_raw_count = r_raw_count + CW'(1);
                if (raw_pos >= ccfd_pkg::POS_CRC_FEED) begin
                    n_crc_acc = crc_feed(r_crc_acc, r_crc_tail[7:0]);
                end
                n_crc_tail = {raw_b, r_crc_tail[15:8]};
                if (raw_pos == ccfd_pkg::POS_VERSION) begin
                    n_version = raw_b;
                end
                if (raw_pos == ccfd_pkg::POS_TYPE) begin
                    n_type = raw_b;
                end
                if (raw_pos == ccfd_pkg::POS_SEQ_LO) begin
                    n_sequence = {r_sequence[15:8], raw_b};
                end
                if (raw_pos == ccfd_pkg::POS_SEQ_HI) begin
                    n_sequence = {raw_b, r_sequence[7:0]};
                end
                if (raw_pos == ccfd_pkg::POS_LEN_LO) begin
                    n_length = {r_length[15:8], raw_b};
                end
                if (raw_pos == ccfd_pkg::POS_LEN_HI) begin
                    n_length = {raw_b, r_length[7:0]};
                end
                if (raw_pos >= ccfd_pkg::HDR_BYTES && pay_pos < 32'(r_length)
                        && pay_pos < MAX_PAYLOAD) begin
                    o_res_valid         = 1'b1;
                    o_res.payload_byte  = raw_b;
                    o_res.payload_index = pay_pos[7:0];
                end
            end
        end

        if (i_accept && i_byte == 8'h00) begin
            o_res_valid          = 1'b1;
            o_res.is_status      = 1'b1;
            o_res.frame_version  = r_version;
            o_res.frame_type     = r_type;
            o_res.frame_sequence = r_sequence;
            o_res.frame_length   = r_length;
            if (r_group_left != 8'h00) begin
                o_res.status = ccfd_pkg::ST_COBS;
            end else if (raw_pos < ccfd_pkg::RAW_OVERHEAD) begin
                o_res.status = ccfd_pkg::ST_SHORT;
            end else if (r_first_error != ccfd_pkg::ST_OK || 32'(r_length) > MAX_PAYLOAD
                    || raw_pos != 32'(r_length) + 32'(ccfd_pkg::RAW_OVERHEAD)) begin
                o_res.status = ccfd_pkg::ST_LENGTH;
            end else if (r_crc_acc != r_crc_tail) begin
                o_res.status = ccfd_pkg::ST_CRC;
            end else begin
                o_res.status = ccfd_pkg::ST_OK;
            end
            n_group_left  = 8'h00;
            n_group_full  = 1'b0;
            n_zero_owed   = 1'b0;
            n_raw_count   = '0;
            n_crc_acc     = ccfd_pkg::CRC_INIT;
            n_crc_tail    = 16'h0000;
            n_version     = 8'h00;
            n_type        = 8'h00;
            n_sequence    = 16'h0000;
            n_length      = 16'h0000;
            n_first_error = ccfd_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_left  <= 8'h00;
            r_group_full  <= 1'b0;
            r_zero_owed   <= 1'b0;
            r_raw_count   <= '0;
            r_crc_acc     <= ccfd_pkg::CRC_INIT;
            r_crc_tail    <= 16'h0000;
            r_version     <= 8'h00;
            r_type        <= 8'h00;
            r_sequence    <= 16'h0000;
            r_length      <= 16'h0000;
            r_first_error <= ccfd_pkg::ST_OK;
        end else begin
            r_group_left  <= n_group_left;
            r_group_full  <= n_group_full;
            r_zero_owed   <= n_zero_owed;
            r_raw_count   <= n_raw_count;
            r_crc_acc     <= n_crc_acc;
            r_crc_tail    <= n_crc_tail;
            r_version     <= n_version;
            r_type        <= n_type;
            r_sequence    <= n_sequence;
            r_length      <= n_length;
            r_first_error <= n_first_error;
        end
    end

    `CCFD_ASSERT_NOW(a_owed_only_between_groups, i_clk, i_rst_n, r_zero_owed, r_group_left == 8'h00)
    `CCFD_ASSERT_NOW(a_count_saturates, i_clk, i_rst_n, 1'b1, raw_pos <= RAW_CAP + 1)
    `CCFD_ASSERT_NEXT(a_delim_clears, i_clk, i_rst_n, i_accept && i_byte == 8'h00, r_raw_count == '0 && r_crc_acc == ccfd_pkg::CRC_INIT)

endmodule

[rtl/ccfd_obuf.sv]
`include "cobs_crc_frame_decoder_assert.svh"

module ccfd_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ccfd_pkg::t_result i_res,
    output logic              o_space,
    output logic              o_valid,
    output ccfd_pkg::t_result o_res,
    input  logic              i_ready
);

    logic              r_out_valid;
    logic              r_skid_valid;
    ccfd_pkg::t_result r_out;
    ccfd_pkg::t_result r_skid;
    logic              out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_valid) begin
            r_skid <= i_res;
        end
    end

    `CCFD_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `CCFD_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && i_ready, !r_skid_valid && r_out_valid)

endmodule

[rtl/cobs_crc_frame_decoder.sv]
// channel  | dir | transaction                 | tdata / tuser
// s_axis   | in  | one stream byte, 0 = delim  | tdata[7:0] byte_in
// m_axis   | out | payload byte or frame status| see port comments
//
// one byte per cycle sustained while s_axis_tready is high, decode and crc update in the accepting cycle
// a result is registered in the output register, or in the skid entry while m_axis stalls, before it shows on m_axis
// output register plus one skid entry; s_axis_tready drops only when the skid is full
// synchronous active-low reset returns the deframer to the start of a frame

module cobs_crc_frame_decoder #(
    parameter int unsigned MAX_PAYLOAD = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // payload_byte, payload_index, status, frame_version, frame_type,
    // frame_sequence, frame_length, zero pad
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tuser   // is_status
);

    logic              accept;
    logic              res_valid;
    ccfd_pkg::t_result res;
    ccfd_pkg::t_result out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    ccfd_dec #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (s_axis_tdata),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    ccfd_obuf u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(res_valid),
        .i_res  (res),
        .o_space(s_axis_tready),
        .o_valid(m_axis_tvalid),
        .o_res  (out_res),
        .i_ready(m_axis_tready)
    );

    assign m_axis_tuser = out_res.is_status;
    assign m_axis_tdata = {5'b00000, out_res.frame_length, out_res.frame_sequence,
                           out_res.frame_type, out_res.frame_version, 3'(out_res.status),
                           out_res.payload_index, out_res.payload_byte};

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_PAYLOAD = 256;
    localparam int unsigned RAW_CAP = MAX_PAYLOAD + ccfd_pkg::RAW_OVERHEAD;
    localparam int RANDOM_BYTES = 200;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTED = 40;
    localparam int SEND_IDLE[4] = '{0, 57, 0, 22};
    localparam int RECV_STALL[4] = '{0, 0, 57, 22};

    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_LEN,
        FR_HUGE_LEN,
        FR_OVERFLOW,
        FR_SHORT,
        FR_TRUNC,
        FR_GARBLED,
        FR_NOISE
    } t_frame_kind;

    typedef struct {
        logic [7:0]        data;
        bit                given;
        ccfd_pkg::t_result want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asks = 0;
    int err_count = 0;
    int cycle_count = 0;
    int bytes_fed = 0;

    ccfd_pkg::t_result due_results[$];
    t_dir_row          dir_rows[$];

    // decoder state mirror
    logic [7:0]        cobs_left;
    bit                cobs_full;
    bit                zero_due;
    int unsigned       raw_seen;
    logic [15:0]       crc_run;
    logic [15:0]       crc_rx;
    logic [7:0]        hdr_ver;
    logic [7:0]        hdr_typ;
    logic [15:0]       hdr_seq;
    logic [15:0]       hdr_len;
    ccfd_pkg::t_status frame_err;

    always #6 i_clk = ~i_clk;

    cobs_crc_frame_decoder #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // byte_in
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // payload_byte, payload_index, status, frame_version, frame_type,
        // frame_sequence, frame_length, zero pad
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)    // is_status
    );

    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
        c = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ ccfd_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic void clear_frame();
        cobs_left = 8'h00;
        cobs_full = 1'b0;
        zero_due  = 1'b0;
        raw_seen  = 0;
        crc_run   = ccfd_pkg::CRC_INIT;
        crc_rx    = 16'h0000;
        hdr_ver   = 8'h00;
        hdr_typ   = 8'h00;
        hdr_seq   = 16'h0000;
        hdr_len   = 16'h0000;
        frame_err = ccfd_pkg::ST_OK;
    endfunction

    function automatic ccfd_pkg::t_result status_of(ccfd_pkg::t_status code, logic [7:0] ver,
                                                    logic [7:0] typ, logic [15:0] seq,
                                                    logic [15:0] len);
        ccfd_pkg::t_result r;
        r = '0;
        r.is_status      = 1'b1;
        r.status         = code;
        r.frame_version  = ver;
        r.frame_type     = typ;
        r.frame_sequence = seq;
        r.frame_length   = len;
        return r;
    endfunction

    function automatic ccfd_pkg::t_result payload_of(logic [7:0] b, logic [7:0] idx);
        ccfd_pkg::t_result r;
        r = '0;
        r.payload_byte  = b;
        r.payload_index = idx;
        return r;
    endfunction

    // one decoded raw byte: header capture, crc, payload emission
    function automatic void absorb_raw(logic [7:0] b, output bit has,
                                       output ccfd_pkg::t_result r);
        int unsigned i;
        int unsigned p;
        has = 1'b0;
        r   = '0;
        i   = raw_seen;
        if (i >= RAW_CAP) begin
            frame_err = ccfd_pkg::ST_LENGTH;
            raw_seen  = RAW_CAP + 1;
            return;
        end
        raw_seen = i + 1;
        if (i >= ccfd_pkg::POS_CRC_FEED) crc_run = crc16_step(crc_run, crc_rx[7:0]);
        crc_rx = {b, crc_rx[15:8]};
        case (i)
            ccfd_pkg::POS_VERSION: hdr_ver = b;
            ccfd_pkg::POS_TYPE:    hdr_typ = b;
            ccfd_pkg::POS_SEQ_LO:  hdr_seq[7:0] = b;
            ccfd_pkg::POS_SEQ_HI:  hdr_seq[15:8] = b;
            ccfd_pkg::POS_LEN_LO:  hdr_len[7:0] = b;
            ccfd_pkg::POS_LEN_HI:  hdr_len[15:8] = b;
            default: ;
        endcase
        if (i >= ccfd_pkg::HDR_BYTES) begin
            p = i - ccfd_pkg::HDR_BYTES;
            if (p < hdr_len && p < MAX_PAYLOAD) begin
                has = 1'b1;
                r   = payload_of(b, p[7:0]);
            end
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b, output bit has,
                                        output ccfd_pkg::t_result r);
        ccfd_pkg::t_status code;
        has = 1'b0;
        r   = '0;
        if (b == 8'h00) begin
            if (cobs_left != 8'h00) begin
                code = ccfd_pkg::ST_COBS;
            end else if (raw_seen < ccfd_pkg::RAW_OVERHEAD) begin
                code = ccfd_pkg::ST_SHORT;
            end else if (frame_err != ccfd_pkg::ST_OK || hdr_len > MAX_PAYLOAD
                         || raw_seen != hdr_len + ccfd_pkg::RAW_OVERHEAD) begin
                code = ccfd_pkg::ST_LENGTH;
            end else if (crc_run != crc_rx) begin
                code = ccfd_pkg::ST_CRC;
            end else begin
                code = ccfd_pkg::ST_OK;
            end
            has = 1'b1;
            r   = status_of(code, hdr_ver, hdr_typ, hdr_seq, hdr_len);
            clear_frame();
        end else if (cobs_left == 8'h00) begin
            if (zero_due) absorb_raw(8'h00, has, r);
            cobs_left = b - 8'd1;
            cobs_full = (b == ccfd_pkg::CODE_FULL);
            zero_due  = (cobs_left == 8'h00) && !cobs_full;
        end else begin
            cobs_left = cobs_left - 8'd1;
            if (cobs_left == 8'h00) zero_due = !cobs_full;
            absorb_raw(b, has, r);
        end
    endfunction

    task automatic report_error(string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) report_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    // returns at the edge where the transaction is accepted
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic feed_byte(logic [7:0] b);
        bit                has;
        ccfd_pkg::t_result r;
        send_byte(b);
        decode_byte(b, has, r);
        if (has) due_results.push_back(r);
        bytes_fed++;
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 55) return FR_GOOD;
        if (r < 63) return FR_BAD_CRC;
        if (r < 70) return FR_BAD_LEN;
        if (r < 75) return FR_HUGE_LEN;
        if (r < 81) return FR_SHORT;
        if (r < 88) return FR_TRUNC;
        if (r < 94) return FR_GARBLED;
        return FR_NOISE;
    endfunction

    task automatic send_frame(t_frame_kind kind, int pay_len, int zero_pct);
        logic [7:0]  raw[$];
        logic [7:0]  grp[$];
        logic [7:0]  wire_q[$];
        logic [15:0] crc;
        logic [15:0] seq;
        logic [15:0] len_field;
        int          n_keep;
        int          n_cut;
        int          pos;
        seq = 16'($urandom_range(16'hFFFF));
        len_field = 16'(pay_len);
        case (kind)
            FR_BAD_LEN: begin
                if (pay_len > 0 && $urandom_range(1) == 1) len_field = 16'(pay_len - 1);
                else len_field = 16'(pay_len + $urandom_range(1, 3));
            end
            FR_HUGE_LEN: len_field = 16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF));
            FR_OVERFLOW: len_field = 16'(MAX_PAYLOAD);
            default: ;
        endcase
        raw.push_back(8'($urandom_range(255)));
        raw.push_back(8'($urandom_range(255)));
        raw.push_back(seq[7:0]);
        raw.push_back(seq[15:8]);
        raw.push_back(len_field[7:0]);
        raw.push_back(len_field[15:8]);
        repeat (pay_len) begin
            if ($urandom_range(99) < zero_pct) raw.push_back(8'h00);
            else raw.push_back(8'($urandom_range(1, 255)));
        end
        crc = ccfd_pkg::CRC_INIT;
        foreach (raw[i]) crc = crc16_step(crc, raw[i]);
        if (kind == FR_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(15));
        raw.push_back(crc[7:0]);
        raw.push_back(crc[15:8]);
        if (kind == FR_SHORT) begin
            n_keep = $urandom_range(0, ccfd_pkg::RAW_OVERHEAD - 1);
            while (raw.size() > n_keep) void'(raw.pop_back());
        end

        // cobs encoding, a full group of 254 owes no zero
        foreach (raw[i]) begin
            if (raw[i] == 8'h00) begin
                wire_q.push_back(8'(grp.size() + 1));
                foreach (grp[j]) wire_q.push_back(grp[j]);
                grp.delete();
            end else begin
                grp.push_back(raw[i]);
                if (grp.size() == 254) begin
                    wire_q.push_back(ccfd_pkg::CODE_FULL);
                    foreach (grp[j]) wire_q.push_back(grp[j]);
                    grp.delete();
                end
            end
        end
        wire_q.push_back(8'(grp.size() + 1));
        foreach (grp[j]) wire_q.push_back(grp[j]);

        case (kind)
            FR_TRUNC: begin
                n_cut = $urandom_range(1, 3);
                while (n_cut > 0 && wire_q.size() > 1) begin
                    void'(wire_q.pop_back());
                    n_cut--;
                end
            end
            FR_GARBLED: begin
                pos = $urandom_range(0, wire_q.size() - 1);
                wire_q[pos] = 8'($urandom_range(1, 255));
            end
            FR_NOISE: begin
                wire_q.delete();
                repeat ($urandom_range(1, 12)) begin
                    if ($urandom_range(7) == 0) wire_q.push_back(8'h00);
                    else wire_q.push_back(8'($urandom_range(1, 255)));
                end
            end
            default: ;
        endcase
        foreach (wire_q[i]) feed_byte(wire_q[i]);
        feed_byte(8'h00);
    endtask

    // receiver: random stalls plus long hold-offs on request
    initial begin : receiver
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_asks) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        ccfd_pkg::t_result got;
        ccfd_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.is_status      = m_axis_tuser;
            got.payload_byte   = m_axis_tdata[7:0];
            got.payload_index  = m_axis_tdata[15:8];
            got.status         = ccfd_pkg::t_status'(m_axis_tdata[18:16]);
            got.frame_version  = m_axis_tdata[26:19];
            got.frame_type     = m_axis_tdata[34:27];
            got.frame_sequence = m_axis_tdata[50:35];
            got.frame_length   = m_axis_tdata[66:51];
            if (due_results.size() == 0) begin
                report_error($sformatf("result with nothing due: tuser %b tdata %h",
                                       m_axis_tuser, m_axis_tdata));
            end else begin
                want = due_results.pop_front();
                check_field("is_status", 16'(got.is_status), 16'(want.is_status));
                check_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
                check_field("payload_index", 16'(got.payload_index),
                            16'(want.payload_index));
                check_field("status", 16'(got.status), 16'(want.status));
                check_field("frame_version", 16'(got.frame_version),
                            16'(want.frame_version));
                check_field("frame_type", 16'(got.frame_type), 16'(want.frame_type));
                check_field("frame_sequence", got.frame_sequence, want.frame_sequence);
                check_field("frame_length", got.frame_length, want.frame_length);
                check_field("tdata pad", 16'(m_axis_tdata[71:67]), 16'h0000);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        bit                has;
        ccfd_pkg::t_result r;
        int                phase_start;

        clear_frame();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty frame
        dir_rows.push_back('{8'h00, 1'b1,
                             status_of(ccfd_pkg::ST_SHORT, 8'h00, 8'h00, 16'h0, 16'h0)});
        // delimiter inside a group
        dir_rows.push_back('{8'h03, 1'b0, '0});
        dir_rows.push_back('{8'hAA, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b1,
                             status_of(ccfd_pkg::ST_COBS, 8'hAA, 8'h00, 16'h0, 16'h0)});
        // owed zeros in header and payload, length field 2 on a frame one raw byte short
        dir_rows.push_back('{8'h06, 1'b0, '0});
        dir_rows.push_back('{8'h01, 1'b0, '0});
        dir_rows.push_back('{8'hFF, 1'b0, '0});
        dir_rows.push_back('{8'h34, 1'b0, '0});
        dir_rows.push_back('{8'h12, 1'b0, '0});
        dir_rows.push_back('{8'h02, 1'b0, '0});
        dir_rows.push_back('{8'h01, 1'b0, '0});
        dir_rows.push_back('{8'h03, 1'b1, payload_of(8'h00, 8'd0)});
        dir_rows.push_back('{8'h11, 1'b1, payload_of(8'h11, 8'd1)});
        dir_rows.push_back('{8'h22, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b1,
                             status_of(ccfd_pkg::ST_LENGTH, 8'h01, 8'hFF, 16'h1234,
                                       16'h0002)});
        // lone zero groups only
        dir_rows.push_back('{8'h01, 1'b0, '0});
        dir_rows.push_back('{8'h01, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b1,
                             status_of(ccfd_pkg::ST_SHORT, 8'h00, 8'h00, 16'h0, 16'h0)});
        // full-group code cut off by the delimiter
        dir_rows.push_back('{8'hFF, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b1,
                             status_of(ccfd_pkg::ST_COBS, 8'h00, 8'h00, 16'h0, 16'h0)});

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].data);
            decode_byte(dir_rows[i].data, has, r);
            if (dir_rows[i].given) due_results.push_back(dir_rows[i].want);
            else if (has) due_results.push_back(r);
        end

        bytes_fed = 0;
        for (int ph = 0; ph < 4; ph++) begin
            pause_until_drained();
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            if (ph == 2) begin
                hold_asks++;
                send_frame(FR_OVERFLOW, MAX_PAYLOAD + $urandom_range(1, 6), 10);
            end
            phase_start = bytes_fed;
            while (bytes_fed - phase_start < RANDOM_BYTES / 4) begin
                send_frame(pick_kind(), $urandom_range(0, 24), 25);
            end
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ccfd_pkg.sv
rtl/ccfd_dec.sv
rtl/ccfd_obuf.sv
rtl/cobs_crc_frame_decoder.sv
tb/sv/tb_top.sv
